### rtl/bcdalu_pkg.sv
// Package with the transaction types and arithmetic functions of the BCD/binary add-subtract ALU.
package bcdalu_pkg;

    typedef logic [7:0] data_t;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    localparam logic [8:0] DEC_WRAP = 9'd100;
    localparam logic [8:0] DEC_MAX = 9'd99;
    localparam data_t DEC_HUNDRED = 8'd100;
    localparam data_t DEC_TWO_HUNDRED = 8'd200;
    localparam logic [14:0] DIV10_RECIP = 15'd205;
    localparam int DIV10_SHIFT = 11;
    localparam data_t SIGN_MASK = 8'h80;

    typedef struct packed {
        logic  op;
        data_t accumulator;
        data_t operand;
        logic  carry_in;
        logic  bcd_mode;
        logic  overflow_in;
    } in_item_t;

    typedef struct packed {
        data_t sum;
        logic  carry_out;
        logic  overflow_out;
        logic  negative;
        logic  zero;
    } result_t;

    // Reads a byte digit-wise as hi*10+lo; nibbles above nine count at face value.
    function automatic data_t dec_value(input data_t b);
        data_t hi;
        data_t lo;
        hi = {4'd0, b[7:4]};
        lo = {4'd0, b[3:0]};
        return (hi << 3) + (hi << 1) + lo;
    endfunction

    // Packs (r mod 100) as two decimal digits.
    function automatic data_t dec_encode(input data_t r);
        logic [6:0]  m;
        logic [14:0] prod;
        logic [3:0]  hi;
        data_t       hi_x10;
        data_t       lo_wide;
        if (r >= DEC_TWO_HUNDRED)
        begin
            m = 7'(r - DEC_TWO_HUNDRED);
        end
        else if (r >= DEC_HUNDRED)
        begin
            m = 7'(r - DEC_HUNDRED);
        end
        else
        begin
            m = r[6:0];
        end
        prod = 15'(m) * DIV10_RECIP;
        hi = prod[DIV10_SHIFT +: 4];
        hi_x10 = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0};
        lo_wide = {1'b0, m} - hi_x10;
        return {hi, lo_wide[3:0]};
    endfunction

    function automatic result_t alu_compute(input in_item_t x);
        result_t     res;
        data_t       da;
        data_t       db;
        data_t       bb;
        data_t       r;
        logic [8:0]  t_add;
        logic [9:0]  t_sub;
        logic [9:0]  t_sub_wrap;
        logic [8:0]  u;
        logic        cout;
        logic        vout;
        da = dec_value(x.accumulator);
        db = dec_value(x.operand);
        bb = (x.op == OP_SUB) ? ~x.operand : x.operand;
        u = {1'b0, x.accumulator} + {1'b0, bb} + {8'd0, x.carry_in};
        t_add = {1'b0, da} + {1'b0, db} + {8'd0, x.carry_in};
        t_sub = {2'b00, da} - {2'b00, db} - {9'd0, ~x.carry_in};
        t_sub_wrap = t_sub + {1'b0, DEC_WRAP};
        if (x.bcd_mode)
        begin
            if (x.op == OP_SUB)
            begin
                cout = ~t_sub[9];
                r = t_sub[9] ? t_sub_wrap[7:0] : t_sub[7:0];
            end
            else
            begin
                cout = (t_add > DEC_MAX);
                r = cout ? 8'(t_add - DEC_WRAP) : t_add[7:0];
            end
            r = dec_encode(r);
            vout = x.overflow_in;
        end
        else
        begin
            cout = u[8];
            r = u[7:0];
            vout = |(~(x.accumulator ^ bb) & (x.accumulator ^ r) & SIGN_MASK);
        end
        res.sum = r;
        res.carry_out = cout;
        res.overflow_out = vout;
        res.negative = r[7];
        res.zero = (r == 8'd0);
        return res;
    endfunction

endpackage

### rtl/bcd_binary_add_subtract_alu.sv
// Top level of the BCD/binary add-subtract ALU with input and result registers.
// An accepted transaction goes into the input register, which feeds the result register.
// Throughput: one transaction per cycle while out_stall does not hold the result.
// A stalled result holds the result register, and the input register then holds too.
// Reset (rst_n, asynchronous, active low) clears only the two valid flags, not the data.
module bcd_binary_add_subtract_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  bcdalu_pkg::data_t  accumulator,
    input  bcdalu_pkg::data_t  operand,
    input  logic               carry_in,
    input  logic               bcd_mode,
    input  logic               overflow_in,
    output logic               out_valid,
    input  logic               out_stall,
    output bcdalu_pkg::data_t  sum,
    output logic               carry_out,
    output logic               overflow_out,
    output logic               negative,
    output logic               zero
);
    import bcdalu_pkg::*;

    logic     s1_valid_reg;
    in_item_t s1_item_reg;
    logic     out_valid_reg;
    result_t  out_item_reg;
    result_t  out_item_next;
    logic     out_load;
    logic     in_accept;

    assign out_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !out_load;
    assign in_accept = in_valid && !in_stall;
    assign out_item_next = alu_compute(s1_item_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (!out_valid_reg || !out_stall)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg.op <= op;
            s1_item_reg.accumulator <= accumulator;
            s1_item_reg.operand <= operand;
            s1_item_reg.carry_in <= carry_in;
            s1_item_reg.bcd_mode <= bcd_mode;
            s1_item_reg.overflow_in <= overflow_in;
        end
        if (out_load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sum = out_item_reg.sum;
    assign carry_out = out_item_reg.carry_out;
    assign overflow_out = out_item_reg.overflow_out;
    assign negative = out_item_reg.negative;
    assign zero = out_item_reg.zero;

`ifndef ASSERT_OFF
    a_accept_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("Accepted transaction did not reach the input register.");

    a_blocked_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_load) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("Blocked input register lost or changed its transaction.");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (zero == (sum == 8'd0)))
        else $error("Zero flag disagrees with the result byte.");

    a_negative_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (negative == sum[7]))
        else $error("Negative flag disagrees with the result byte.");
`endif

endmodule

### verif/bcd_binary_add_subtract_alu_tb.sv
// Self-checking testbench for the BCD/binary add-subtract ALU with random handshake timing.
`timescale 1ns / 1ps

module bcd_binary_add_subtract_alu_tb;

    import bcdalu_pkg::*;

    localparam int RANDOM_OPERATIONS = 1550;
    localparam int DRAIN_CYCLES = 10;
    localparam time RUN_LIMIT = 3ms;

    class alu_result_scoreboard;
        result_t pending_results[$];
        int      failures;

        function new();
            failures = 0;
        endfunction

        function result_t predict_sum_and_flags(in_item_t x);
            result_t    r;
            int         da;
            int         db;
            int         t;
            data_t      bb;
            logic [8:0] u;
            if (x.bcd_mode)
            begin
                da = int'(x.accumulator[7:4]) * 10 + int'(x.accumulator[3:0]);
                db = int'(x.operand[7:4]) * 10 + int'(x.operand[3:0]);
                if (x.op == OP_SUB)
                begin
                    t = da - db - (x.carry_in ? 0 : 1);
                    r.carry_out = (t >= 0);
                    if (t < 0)
                    begin
                        t = t + 100;
                    end
                    t = t & 255;
                end
                else
                begin
                    t = da + db + (x.carry_in ? 1 : 0);
                    r.carry_out = (t > 99);
                    if (t > 99)
                    begin
                        t = t - 100;
                    end
                end
                t = t % 100;
                r.sum = 8'((t / 10) * 16 + (t % 10));
                r.overflow_out = x.overflow_in;
            end
            else
            begin
                bb = (x.op == OP_SUB) ? ~x.operand : x.operand;
                u = {1'b0, x.accumulator} + {1'b0, bb} + {8'd0, x.carry_in};
                r.sum = u[7:0];
                r.carry_out = u[8];
                r.overflow_out = (x.accumulator[7] == bb[7]) && (u[7] != x.accumulator[7]);
            end
            r.negative = r.sum[7];
            r.zero = (r.sum == 8'd0);
            return r;
        endfunction

        function void note_operation(in_item_t x);
            pending_results.push_back(predict_sum_and_flags(x));
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                failures++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none, actual %p",
                         $time, got);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("sum", want.sum, got.sum);
                compare_field("carry_out", want.carry_out, got.carry_out);
                compare_field("overflow_out", want.overflow_out, got.overflow_out);
                compare_field("negative", want.negative, got.negative);
                compare_field("zero", want.zero, got.zero);
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    logic  op = 1'b0;
    data_t accumulator = 8'd0;
    data_t operand = 8'd0;
    logic  carry_in = 1'b0;
    logic  bcd_mode = 1'b0;
    logic  overflow_in = 1'b0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    data_t sum;
    logic  carry_out;
    logic  overflow_out;
    logic  negative;
    logic  zero;

    alu_result_scoreboard alu_results = new();

    bcd_binary_add_subtract_alu dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .accumulator  (accumulator),
        .operand      (operand),
        .carry_in     (carry_in),
        .bcd_mode     (bcd_mode),
        .overflow_in  (overflow_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sum          (sum),
        .carry_out    (carry_out),
        .overflow_out (overflow_out),
        .negative     (negative),
        .zero         (zero)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                alu_results.note_operation({op, accumulator, operand, carry_in,
                                            bcd_mode, overflow_in});
            end
            if (out_valid && !out_stall)
            begin
                alu_results.check_result({sum, carry_out, overflow_out, negative, zero});
            end
        end
    end

    // The receiver redraws its stall behavior at random from four modes, paced by a free-running cycle counter.
    int unsigned stall_mode = 0;
    int unsigned stall_cycle = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            stall_cycle <= stall_cycle + 1;
            if (stall_cycle % 64 == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= stall_cycle[1];
            endcase
        end
    end

    task automatic send_operation(input in_item_t x);
        in_valid <= 1'b1;
        op <= x.op;
        accumulator <= x.accumulator;
        operand <= x.operand;
        carry_in <= x.carry_in;
        bcd_mode <= x.bcd_mode;
        overflow_in <= x.overflow_in;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_directed(input logic o, input data_t a, input data_t b,
                                 input logic c, input logic d, input logic v);
        in_item_t x;
        x = {o, a, b, c, d, v};
        send_operation(x);
    endtask

    function automatic in_item_t random_operation();
        in_item_t x;
        x.op = 1'($urandom);
        x.carry_in = 1'($urandom);
        x.bcd_mode = 1'($urandom);
        x.overflow_in = 1'($urandom);
        if (x.bcd_mode && $urandom_range(0, 3) != 0)
        begin
            x.accumulator = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            x.operand = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        end
        else
        begin
            x.accumulator = 8'($urandom);
            x.operand = 8'($urandom);
        end
        return x;
    endfunction

    task automatic wait_until_drained();
        @(posedge clk);
        while (alu_results.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int sent;
        int burst;
        int gap;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed(OP_ADD, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        send_directed(OP_ADD, 8'hff, 8'hff, 1'b1, 1'b0, 1'b1);
        send_directed(OP_ADD, 8'h7f, 8'h01, 1'b0, 1'b0, 1'b0);
        send_directed(OP_ADD, 8'h80, 8'h80, 1'b0, 1'b0, 1'b0);
        send_directed(OP_ADD, 8'hff, 8'h00, 1'b1, 1'b0, 1'b0);
        send_directed(OP_SUB, 8'h00, 8'h01, 1'b1, 1'b0, 1'b0);
        send_directed(OP_SUB, 8'h80, 8'h01, 1'b1, 1'b0, 1'b0);
        send_directed(OP_SUB, 8'h7f, 8'hff, 1'b1, 1'b0, 1'b1);
        send_directed(OP_SUB, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        send_directed(OP_SUB, 8'h55, 8'h55, 1'b1, 1'b0, 1'b1);
        send_directed(OP_ADD, 8'h99, 8'h01, 1'b0, 1'b1, 1'b0);
        send_directed(OP_ADD, 8'h99, 8'h99, 1'b1, 1'b1, 1'b1);
        send_directed(OP_ADD, 8'hff, 8'hff, 1'b1, 1'b1, 1'b0);
        send_directed(OP_ADD, 8'h0a, 8'h0f, 1'b0, 1'b1, 1'b1);
        send_directed(OP_ADD, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
        send_directed(OP_ADD, 8'h50, 8'h50, 1'b0, 1'b1, 1'b0);
        send_directed(OP_SUB, 8'h00, 8'hff, 1'b0, 1'b1, 1'b1);
        send_directed(OP_SUB, 8'h00, 8'h01, 1'b1, 1'b1, 1'b0);
        send_directed(OP_SUB, 8'h50, 8'h50, 1'b1, 1'b1, 1'b1);
        send_directed(OP_SUB, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
        send_directed(OP_SUB, 8'hff, 8'h00, 1'b1, 1'b1, 1'b0);
        send_directed(OP_SUB, 8'h99, 8'h99, 1'b0, 1'b1, 1'b1);
        send_directed(OP_SUB, 8'hf0, 8'h0f, 1'b1, 1'b1, 1'b0);

        sent = 0;
        while (sent < RANDOM_OPERATIONS)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < RANDOM_OPERATIONS)
            begin
                send_operation(random_operation());
                sent++;
                burst--;
                if (sent == RANDOM_OPERATIONS / 2)
                begin
                    in_valid <= 1'b0;
                    wait_until_drained();
                end
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (alu_results.failures == 0 && alu_results.outstanding() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/bcdalu_pkg.sv
rtl/bcd_binary_add_subtract_alu.sv
verif/bcd_binary_add_subtract_alu_tb.sv
